// ===== rtl/eogbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// EOG blink and gaze detector package
// Shared widths, configuration register indexes and the divider interface.
// ============================================================================
package eogbg_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int WINDOW_LEN   = 8;
    localparam int WIN_IDX_BITS = $clog2(WINDOW_LEN);
    localparam int WIN_CNT_BITS = $clog2(WINDOW_LEN + 1);
    localparam int SUM_BITS     = SAMPLE_BITS + WIN_IDX_BITS;
    localparam int TIME_BITS    = 32;
    localparam int MS_BITS      = 16;
    localparam int SENS_BITS    = 5;
    localparam int EYE_BITS     = 11;
    localparam int EYE_LIMIT    = 512;
    localparam int BASE_SHIFT   = 9;
    localparam int BASE_ACC_BITS = SAMPLE_BITS + BASE_SHIFT;
    localparam int KIND_BITS    = 2;

    // Shared divider sizes: the dividend covers the window sum and the offset
    // magnitude, the divisor covers the fill count and the sensitivity.
    localparam int DIV_N_BITS   = SUM_BITS;
    localparam int DIV_D_BITS   = (WIN_CNT_BITS > SENS_BITS) ? WIN_CNT_BITS : SENS_BITS;
    localparam int DIV_CNT_BITS = $clog2(DIV_N_BITS);

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPIKE_THR  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_BLINK  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BLINK  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REFRACTORY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOUBLE_WIN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_ZONE  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SENS_DIV   = 3'd6;
    localparam int CFG_DATA_BITS = 16;

    // Blink classification codes
    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_SINGLE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DOUBLE = 2'd2;

    // Input item codes
    localparam logic ACTION_SAMPLE    = 1'b0;
    localparam logic ACTION_CALIBRATE = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [DIV_N_BITS-1:0] dividend;
        logic [DIV_D_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_N_BITS-1:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

// ===== rtl/eog_blink_gaze_detector_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// EOG blink and gaze detector
// Filters EOG samples, tracks the baseline, classifies blinks and reports the
// scaled eye offset.
// ============================================================================
// Each sample transaction passes through an 8-tap moving average, a slow
// 511/512 baseline tracker that is frozen during a spike or with leads off, a
// hysteresis blink classifier and a dead-zoned, scaled eye offset saturated to
// +/-512. One sample transaction produces exactly one result transaction; a calibrate
// transaction (tuser action bit set) loads the baseline, fills the window and
// clears the blink state without producing a result. Items are handled one at
// a time by a small sequencer around a single restoring divider that yields
// one quotient bit per cycle: the window average uses it once and the eye offset
// scaling uses it a second time when leads are on and the offset lies outside
// the dead zone. The result sits in an output register, so the next item is
// accepted while a result still waits on m_axis_tready. Configuration writes are
// taken in every cycle and must only be issued while the block is idle.
module eog_blink_gaze_detector_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // [11:0] sample, [43:12] now_ms, [47:44] zero
    input  wire  [1:0]  s_axis_tuser,   // [0] action, [1] lead_loss
    // Results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [11:0] used_sample, [23:12] filtered,
                                        // [35:24] baseline_now, [46:36] eye_offset,
                                        // [47] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] blink_kind, [2] lead_loss_echo
    // Configuration writes
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [eogbg_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire  [eogbg_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import eogbg_pkg::*;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PUSH  = 3'd1;
    localparam logic [2:0] ST_DIVA  = 3'd2;
    localparam logic [2:0] ST_WAITA = 3'd3;
    localparam logic [2:0] ST_BASE  = 3'd4;
    localparam logic [2:0] ST_BLINK = 3'd5;
    localparam logic [2:0] ST_WAITB = 3'd6;
    localparam logic [2:0] ST_FIN   = 3'd7;

    // Configuration registers
    logic [SAMPLE_BITS-1:0] r_thr;
    logic [MS_BITS-1:0]     r_min_ms;
    logic [MS_BITS-1:0]     r_max_ms;
    logic [MS_BITS-1:0]     r_refr_ms;
    logic [MS_BITS-1:0]     r_dwin_ms;
    logic [SAMPLE_BITS-1:0] r_dead;
    logic [SENS_BITS-1:0]   r_sens;

    // Sequencer and item
    logic [2:0]             r_state;
    logic [2:0]             n_state;
    logic                   r_action;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_off;
    logic [TIME_BITS-1:0]   r_now;

    // Processing state
    logic [SAMPLE_BITS-1:0] r_used;
    logic [SAMPLE_BITS-1:0] r_filt;
    logic [SAMPLE_BITS-1:0] r_base;
    logic [EYE_BITS-1:0]    r_eye;
    logic [KIND_BITS-1:0]   r_kind;
    logic                   r_eye_neg;
    logic                   r_in_spike;
    logic [TIME_BITS-1:0]   r_spike_ms;
    logic [TIME_BITS-1:0]   r_last_ms;
    logic                   r_pending;
    logic [TIME_BITS-1:0]   r_first_ms;

    // Output register
    logic                   r_out_valid;
    logic [47:0]            r_out_data;
    logic [2:0]             r_out_user;

    // Blink next values
    logic                   n_in_spike;
    logic [TIME_BITS-1:0]   n_spike_ms;
    logic [TIME_BITS-1:0]   n_last_ms;
    logic                   n_pending;
    logic [TIME_BITS-1:0]   n_first_ms;
    logic [KIND_BITS-1:0]   n_kind;

    logic                   w_accept;
    logic                   w_load_out;
    logic [SUM_BITS-1:0]    w_win_sum;
    logic [WIN_CNT_BITS-1:0] w_win_count;
    logic [BASE_ACC_BITS-1:0] w_base_acc;
    logic [SAMPLE_BITS:0]   w_offset;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic                   w_in_dead;
    logic [SENS_BITS-1:0]   w_sens;
    logic [EYE_BITS-2:0]    w_sat;
    logic [EYE_BITS-1:0]    w_eye;
    t_div_req               w_div_req;
    t_div_rsp               w_div_rsp;

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    // ------------------------------------------------------------------------
    // Configuration registers. An index past the list is ignored.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= SAMPLE_BITS'(80);
            r_min_ms  <= MS_BITS'(30);
            r_max_ms  <= MS_BITS'(300);
            r_refr_ms <= MS_BITS'(250);
            r_dwin_ms <= MS_BITS'(650);
            r_dead    <= SAMPLE_BITS'(10);
            r_sens    <= SENS_BITS'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SPIKE_THR:  r_thr     <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_MIN_BLINK:  r_min_ms  <= i_cfg_data[MS_BITS-1:0];
                CFG_MAX_BLINK:  r_max_ms  <= i_cfg_data[MS_BITS-1:0];
                CFG_REFRACTORY: r_refr_ms <= i_cfg_data[MS_BITS-1:0];
                CFG_DOUBLE_WIN: r_dwin_ms <= i_cfg_data[MS_BITS-1:0];
                CFG_DEAD_ZONE:  r_dead    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_SENS_DIV:   r_sens    <= i_cfg_data[SENS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Window and shared divider
    // ------------------------------------------------------------------------
    eogbg_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  ((r_state == ST_PUSH) && (r_action == ACTION_SAMPLE)),
        .i_fill  ((r_state == ST_PUSH) && (r_action == ACTION_CALIBRATE)),
        .i_value ((r_action == ACTION_SAMPLE && r_off) ? r_base : r_sample),
        .o_sum   (w_win_sum),
        .o_count (w_win_count)
    );

    // The divider is started once for the window average and, when the leads are on
    // and the offset lies outside the dead zone, once more for the sensitivity scaling.
    assign w_sens = (r_sens == '0) ? SENS_BITS'(1) : r_sens;

    always_comb begin
        w_div_req.start    = 1'b0;
        w_div_req.dividend = DIV_N_BITS'(w_win_sum);
        w_div_req.divisor  = DIV_D_BITS'(w_win_count);
        if (r_state == ST_DIVA) begin
            w_div_req.start = 1'b1;
        end else if (r_state == ST_BLINK) begin
            w_div_req.start    = !w_in_dead;
            w_div_req.dividend = DIV_N_BITS'(w_mag);
            w_div_req.divisor  = DIV_D_BITS'(w_sens);
        end
    end

    eogbg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------------
    // Baseline, offset and blink classification
    // ------------------------------------------------------------------------
    // baseline * 511 + filtered, formed as a shift and a subtraction.
    assign w_base_acc = {r_base, BASE_SHIFT'(0)} - BASE_ACC_BITS'(r_base)
                        + BASE_ACC_BITS'(r_filt);

    // The offset and its magnitude are taken against the baseline already
    // updated for this sample.
    assign w_offset  = {1'b0, r_filt} - {1'b0, r_base};
    assign w_mag     = w_offset[SAMPLE_BITS] ? SAMPLE_BITS'(-w_offset)
                                             : w_offset[SAMPLE_BITS-1:0];
    assign w_in_dead = (w_mag < r_dead);

    always_comb begin
        logic                 spike;
        logic                 counted;
        logic [TIME_BITS-1:0] dur;
        spike      = r_in_spike;
        n_spike_ms = r_spike_ms;
        n_last_ms  = r_last_ms;
        n_pending  = r_pending;
        n_first_ms = r_first_ms;
        n_kind     = KIND_NONE;
        counted    = 1'b0;
        dur        = '0;
        if (!spike && (w_mag > r_thr)) begin
            spike      = 1'b1;
            n_spike_ms = r_now;
        end
        // A spike ends once the deviation drops below half the threshold.
        if (spike && (w_mag < (r_thr >> 1))) begin
            spike   = 1'b0;
            dur     = r_now - n_spike_ms;
            counted = (dur >= TIME_BITS'(r_min_ms)) && (dur <= TIME_BITS'(r_max_ms))
                      && ((r_now - r_last_ms) > TIME_BITS'(r_refr_ms));
        end
        if (counted) begin
            n_last_ms = r_now;
            if (!n_pending) begin
                n_pending  = 1'b1;
                n_first_ms = r_now;
            end else if ((r_now - n_first_ms) < TIME_BITS'(r_dwin_ms)) begin
                n_pending = 1'b0;
                n_kind    = KIND_DOUBLE;
            end
        end
        // A first blink with no partner inside the window is a single blink.
        if (n_pending && ((r_now - n_first_ms) >= TIME_BITS'(r_dwin_ms))) begin
            n_pending = 1'b0;
            n_kind    = KIND_SINGLE;
        end
        n_in_spike = spike;
    end

    // Saturate the scaled magnitude, then restore the sign.
    assign w_sat = (w_div_rsp.quotient > DIV_N_BITS'(EYE_LIMIT))
                   ? (EYE_BITS-1)'(EYE_LIMIT) : w_div_rsp.quotient[EYE_BITS-2:0];
    assign w_eye = r_eye_neg ? -{1'b0, w_sat} : {1'b0, w_sat};

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    assign w_load_out = (r_state == ST_FIN) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_PUSH;
            ST_PUSH:  n_state = (r_action == ACTION_CALIBRATE) ? ST_IDLE : ST_DIVA;
            ST_DIVA:  n_state = ST_WAITA;
            ST_WAITA: if (w_div_rsp.done) n_state = r_off ? ST_FIN : ST_BASE;
            ST_BASE:  n_state = ST_BLINK;
            ST_BLINK: n_state = w_in_dead ? ST_FIN : ST_WAITB;
            ST_WAITB: if (w_div_rsp.done) n_state = ST_FIN;
            ST_FIN:   if (w_load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_base     <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
            r_in_spike <= 1'b0;
            r_spike_ms <= '0;
            r_last_ms  <= '0;
            r_pending  <= 1'b0;
            r_first_ms <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_PUSH: begin
                    if (r_action == ACTION_CALIBRATE) begin
                        r_base     <= r_sample;
                        r_in_spike <= 1'b0;
                        r_pending  <= 1'b0;
                    end
                end
                ST_BASE: begin
                    if (!r_in_spike) begin
                        r_base <= w_base_acc[BASE_ACC_BITS-1:BASE_SHIFT];
                    end
                end
                ST_BLINK: begin
                    r_in_spike <= n_in_spike;
                    r_spike_ms <= n_spike_ms;
                    r_last_ms  <= n_last_ms;
                    r_pending  <= n_pending;
                    r_first_ms <= n_first_ms;
                end
                default: ;
            endcase
        end
    end

    // Item and intermediate payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= s_axis_tuser[0];
            r_off    <= s_axis_tuser[1];
            r_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
            r_now    <= s_axis_tdata[SAMPLE_BITS +: TIME_BITS];
        end
        case (r_state)
            ST_PUSH: begin
                r_used <= r_off ? r_base : r_sample;
                r_kind <= KIND_NONE;
                r_eye  <= '0;
            end
            ST_WAITA: begin
                if (w_div_rsp.done) begin
                    r_filt <= w_div_rsp.quotient[SAMPLE_BITS-1:0];
                end
            end
            ST_BLINK: begin
                r_kind    <= n_kind;
                r_eye_neg <= w_offset[SAMPLE_BITS];
            end
            ST_WAITB: begin
                if (w_div_rsp.done) begin
                    r_eye <= w_eye;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= {1'b0, r_eye, r_base, r_filt, r_used};
            r_out_user <= {r_off, r_kind};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // The divider runs a full pass, so completion never follows a start directly.
    a_div_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> !w_div_rsp.done)
        else $error("divider completed one cycle after start");

    // A start is only issued to an idle divider.
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    // A result taken with leads off carries no blink and a zero eye offset.
    a_lead_loss_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |->
        (m_axis_tuser[1:0] == KIND_NONE && m_axis_tdata[46:36] == '0))
        else $error("leads-off result carries blink or eye data");

    // After an item is accepted the block stays busy for the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("input accepted twice in consecutive cycles");

    // A sample transaction always yields one of the defined blink codes.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] == KIND_NONE
                           || m_axis_tuser[1:0] == KIND_SINGLE
                           || m_axis_tuser[1:0] == KIND_DOUBLE))
        else $error("undefined blink code on result");

endmodule
`default_nettype wire

// ===== rtl/eogbg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// EOG detector shared divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ============================================================================
module eogbg_div (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire eogbg_pkg::t_div_req i_req,
    output eogbg_pkg::t_div_rsp      o_rsp
);
    import eogbg_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic [DIV_N_BITS-1:0]   r_dvd;
    logic [DIV_D_BITS-1:0]   r_dvs;
    logic [DIV_D_BITS-1:0]   r_rem;

    logic [DIV_D_BITS:0]     w_shift;
    logic                    w_fit;
    logic [DIV_D_BITS:0]     w_diff;

    // The dividend shifts out at the top while quotient bits enter at the bottom.
    assign w_shift = {r_rem, r_dvd[DIV_N_BITS-1]};
    assign w_fit   = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_BITS'(DIV_N_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIV_N_BITS-2:0], w_fit};
            r_rem <= w_fit ? w_diff[DIV_D_BITS-1:0] : w_shift[DIV_D_BITS-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule
`default_nettype wire

// ===== rtl/eogbg_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// EOG detector moving-average window
// Holds the sample window, its running sum, write index and fill count.
// ============================================================================
module eogbg_window (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_push,
    input  wire                               i_fill,
    input  wire [eogbg_pkg::SAMPLE_BITS-1:0]  i_value,
    output logic [eogbg_pkg::SUM_BITS-1:0]    o_sum,
    output logic [eogbg_pkg::WIN_CNT_BITS-1:0] o_count
);
    import eogbg_pkg::*;

    logic [SAMPLE_BITS-1:0]  r_store [WINDOW_LEN];
    logic [WIN_IDX_BITS-1:0] r_idx;
    logic [SUM_BITS-1:0]     r_sum;
    logic                    r_full;

    logic [WIN_IDX_BITS-1:0] n_idx;
    logic [WIN_CNT_BITS-1:0] w_count;

    assign n_idx = (r_idx == WIN_IDX_BITS'(WINDOW_LEN - 1)) ? '0 : r_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_store[i] <= '0;
            end
            r_idx  <= '0;
            r_sum  <= '0;
            r_full <= 1'b0;
        end else if (i_fill) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
                r_store[i] <= i_value;
            end
            r_idx  <= '0;
            r_sum  <= SUM_BITS'(i_value) * SUM_BITS'(WINDOW_LEN);
            r_full <= 1'b1;
        end else if (i_push) begin
            r_store[r_idx] <= i_value;
            r_sum  <= r_sum - SUM_BITS'(r_store[r_idx]) + SUM_BITS'(i_value);
            r_idx  <= n_idx;
            if (n_idx == '0) begin
                r_full <= 1'b1;
            end
        end
    end

    // Until the window has wrapped once, average over the entries written so far.
    assign w_count = r_full ? WIN_CNT_BITS'(WINDOW_LEN) : WIN_CNT_BITS'(r_idx);
    assign o_count = (w_count == '0) ? WIN_CNT_BITS'(1) : w_count;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// EOG blink and gaze detector testbench
// Drives sample and calibrate transactions into the detector and keeps its own
// model of the filter, baseline, blink classifier and eye offset. Every result
// transaction is checked field by field against the oldest predicted result.
// ============================================================================
module testbench;
    import eogbg_pkg::*;

    localparam int HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int SETTLE_CYCLES = 60;   // covers the slowest item
    localparam int MAX_REPORTS   = 100;  // keeps the log short on a bad run

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] used;
        logic [SAMPLE_BITS-1:0] filt;
        logic [SAMPLE_BITS-1:0] base;
        logic [EYE_BITS-1:0]    eye;
        logic [KIND_BITS-1:0]   kind;
        logic                   lead_loss;
    } t_eog_result;

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = '0;   // [11:0] sample, [43:12] now_ms, [47:44] zero
    logic [1:0]  s_axis_tuser  = '0;   // [0] action, [1] lead_loss
    logic        m_axis_tready = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [47:0] m_axis_tdata;   // [11:0] used, [23:12] filtered, [35:24] baseline,
                                 // [46:36] eye_offset, [47] zero
    logic [2:0]  m_axis_tuser;   // [1:0] blink_kind, [2] lead_loss_echo
    logic        o_cfg_ready;

    always #5 i_clk = ~i_clk;

    eog_blink_gaze_detector_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_eog_result expected_results[$];
    int          error_count    = 0;
    int          samples_sent   = 0;
    int          send_idle_pct  = 0;   // chance in a hundred that the sender idles a cycle
    int          recv_stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int          hold_requests  = 0;
    int          holds_served   = 0;
    logic [31:0] stamp_ms       = '0;  // running timestamp for the random traffic

    // Detector model state: the moving-average window, the baseline tracker,
    // the blink classifier and a copy of the configuration registers.
    logic [SAMPLE_BITS-1:0] mdl_win [WINDOW_LEN];
    int unsigned            mdl_idx;
    int unsigned            mdl_sum;
    bit                     mdl_full;
    logic [SAMPLE_BITS-1:0] mdl_base;
    bit                     mdl_spike;
    logic [31:0]            mdl_spike_ms;
    logic [31:0]            mdl_last_ms;
    bit                     mdl_first_pend;
    logic [31:0]            mdl_first_ms;
    logic [15:0]            mdl_cfg [7];

    task automatic reset_detector_model();
        int i;
        for (i = 0; i < WINDOW_LEN; i++) mdl_win[i] = '0;
        mdl_idx        = 0;
        mdl_sum        = 0;
        mdl_full       = 1'b0;
        mdl_base       = 12'd2048;
        mdl_spike      = 1'b0;
        mdl_spike_ms   = '0;
        mdl_last_ms    = '0;
        mdl_first_pend = 1'b0;
        mdl_first_ms   = '0;
        mdl_cfg[CFG_SPIKE_THR]  = 16'd80;
        mdl_cfg[CFG_MIN_BLINK]  = 16'd30;
        mdl_cfg[CFG_MAX_BLINK]  = 16'd300;
        mdl_cfg[CFG_REFRACTORY] = 16'd250;
        mdl_cfg[CFG_DOUBLE_WIN] = 16'd650;
        mdl_cfg[CFG_DEAD_ZONE]  = 16'd10;
        mdl_cfg[CFG_SENS_DIV]   = 16'd1;
    endtask

    // Applies one accepted transaction to the model and queues the result it
    // gives, if any. A calibrate transaction only reloads the state.
    function automatic void predict_detector_item(logic act, logic [11:0] smp, logic lo,
                                                  logic [31:0] now);
        t_eog_result r;
        int          i, count, thr, dev, delta, dv, q;
        logic [31:0] dur, since_last;

        if (act == ACTION_CALIBRATE) begin
            mdl_base = smp;
            mdl_sum  = 0;
            for (i = 0; i < WINDOW_LEN; i++) begin
                mdl_win[i] = smp;
                mdl_sum += smp;
            end
            mdl_idx        = 0;
            mdl_full       = 1'b1;
            mdl_spike      = 1'b0;
            mdl_first_pend = 1'b0;
            return;
        end

        // While the leads are off the baseline stands in for the sample.
        r.used = lo ? mdl_base : smp;
        mdl_sum = mdl_sum - mdl_win[mdl_idx] + r.used;
        mdl_win[mdl_idx] = r.used;
        mdl_idx = (mdl_idx + 1 >= WINDOW_LEN) ? 0 : mdl_idx + 1;
        if (mdl_idx == 0) mdl_full = 1'b1;
        count = mdl_full ? WINDOW_LEN : mdl_idx;
        if (count == 0) count = 1;
        r.filt = 12'(mdl_sum / count);
        r.kind = KIND_NONE;
        r.eye  = '0;

        if (!lo) begin
            if (!mdl_spike)
                mdl_base = 12'((mdl_base * ((1 << BASE_SHIFT) - 1) + r.filt) >> BASE_SHIFT);

            // Hysteresis spike detector against the updated baseline.
            dev   = int'(r.filt) - int'(mdl_base);
            delta = (dev < 0) ? -dev : dev;
            thr   = mdl_cfg[CFG_SPIKE_THR];
            if (!mdl_spike && delta > thr) begin
                mdl_spike    = 1'b1;
                mdl_spike_ms = now;
            end
            if (mdl_spike && delta < thr / 2) begin
                dur        = now - mdl_spike_ms;
                since_last = now - mdl_last_ms;
                mdl_spike  = 1'b0;
                if (dur >= {16'd0, mdl_cfg[CFG_MIN_BLINK]} &&
                    dur <= {16'd0, mdl_cfg[CFG_MAX_BLINK]} &&
                    since_last > {16'd0, mdl_cfg[CFG_REFRACTORY]}) begin
                    mdl_last_ms = now;
                    if (!mdl_first_pend) begin
                        mdl_first_pend = 1'b1;
                        mdl_first_ms   = now;
                    end else if (32'(now - mdl_first_ms) < {16'd0, mdl_cfg[CFG_DOUBLE_WIN]}) begin
                        mdl_first_pend = 1'b0;
                        r.kind         = KIND_DOUBLE;
                    end
                end
            end
            // A first blink whose double window has run out is a single blink.
            if (mdl_first_pend && 32'(now - mdl_first_ms) >= {16'd0, mdl_cfg[CFG_DOUBLE_WIN]}) begin
                mdl_first_pend = 1'b0;
                r.kind         = KIND_SINGLE;
            end

            // Dead-zoned, scaled and saturated eye offset.
            dv = (mdl_cfg[CFG_SENS_DIV] == 0) ? 1 : int'(mdl_cfg[CFG_SENS_DIV]);
            if (delta >= int'(mdl_cfg[CFG_DEAD_ZONE])) begin
                q = dev / dv;
                if (q > EYE_LIMIT) q = EYE_LIMIT;
                if (q < -EYE_LIMIT) q = -EYE_LIMIT;
                r.eye = q[EYE_BITS-1:0];
            end
        end
        r.base      = mdl_base;
        r.lead_loss = lo;
        expected_results.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request. The hold-off
    // is counted here so that the sender can keep offering transactions.
    // ------------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each result transaction is compared with the oldest
    // prediction. Signals are read as they stood just before the edge.
    // ------------------------------------------------------------------------
    task automatic check_field(input string label, input logic [11:0] want,
                               input logic [11:0] got);
        if (want !== got) begin
            if (error_count < MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 'h%0h, actual 'h%0h",
                         $time, label, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_eog_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $display("%0t ns: unexpected result, expected none, actual 'h%0h / 'h%0h",
                             $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("used_sample",    want.used,      m_axis_tdata[11:0]);
                check_field("filtered",       want.filt,      m_axis_tdata[23:12]);
                check_field("baseline_now",   want.base,      m_axis_tdata[35:24]);
                check_field("eye_offset",     want.eye,       m_axis_tdata[46:36]);
                check_field("blink_kind",     want.kind,      m_axis_tuser[1:0]);
                check_field("lead_loss_echo", want.lead_loss, m_axis_tuser[2]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Valid is only lowered when the sender idles or pauses, so a
    // run of back-to-back transactions never sees two assignments in a step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic act, input logic [11:0] smp, input logic lo,
                             input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, now, smp};
        s_axis_tuser  <= {lo, act};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_detector_item(act, smp, lo, now);
        if (act == ACTION_SAMPLE) samples_sent++;
    endtask

    task automatic send_sample(input logic [11:0] smp, input logic lo);
        stamp_ms += $urandom_range(1, 40);
        send_item(ACTION_SAMPLE, smp, lo, stamp_ms);
    endtask

    // Stops offering and waits until every predicted result has arrived, then
    // lets a calibrate that gives no result finish as well.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SPIKE_THR, CFG_DEAD_ZONE: mdl_cfg[idx] = data & 16'h0FFF;
            CFG_SENS_DIV:                 mdl_cfg[idx] = data & 16'h001F;
            default:                      mdl_cfg[idx] = data;
        endcase
    endtask

    // Writes the whole register set while the block is idle.
    task automatic apply_config(input logic [15:0] thr, input logic [15:0] min_ms,
                                input logic [15:0] max_ms, input logic [15:0] refr_ms,
                                input logic [15:0] dwin_ms, input logic [15:0] dz,
                                input logic [15:0] sens);
        settle_block();
        write_reg(CFG_SPIKE_THR,  thr);
        write_reg(CFG_MIN_BLINK,  min_ms);
        write_reg(CFG_MAX_BLINK,  max_ms);
        write_reg(CFG_REFRACTORY, refr_ms);
        write_reg(CFG_DOUBLE_WIN, dwin_ms);
        write_reg(CFG_DEAD_ZONE,  dz);
        write_reg(CFG_SENS_DIV,   sens);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    function automatic logic [11:0] clamp_sample(int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return v[11:0];
    endfunction

    function automatic logic random_lead_loss();
        return $urandom_range(0, 99) < 4;
    endfunction

    // A well-formed blink: a few samples away from the baseline, then four to twelve
    // samples at rest, then a quiet gap of random length.
    task automatic blink_episode();
        int level, amp, n_high, n_rest, k;
        level  = mdl_base;
        amp    = $urandom_range(40, 1800);
        if ($urandom_range(0, 1)) amp = -amp;
        n_high = $urandom_range(1, 4);
        n_rest = $urandom_range(4, 12);
        for (k = 0; k < n_high; k++)
            send_sample(clamp_sample(level + amp + $urandom_range(0, 20) - 10),
                        random_lead_loss());
        for (k = 0; k < n_rest; k++)
            send_sample(clamp_sample(level + $urandom_range(0, 12) - 6), random_lead_loss());
        stamp_ms += $urandom_range(0, 800);
    endtask

    // Noise: arbitrary samples, random leads-off and jumps of the timestamp,
    // some of them right up to the wrap.
    task automatic noise_item();
        case ($urandom_range(0, 9))
            0, 1, 2: stamp_ms = $urandom();
            3:       stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
            default: stamp_ms += $urandom_range(0, 60);
        endcase
        send_item(ACTION_SAMPLE, 12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                  stamp_ms);
    endtask

    task automatic random_traffic(input int n);
        int target, pick;
        target = samples_sent + n;
        while (samples_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_item(ACTION_CALIBRATE, 12'($urandom_range(0, 4095)),
                          1'($urandom_range(0, 1)), $urandom());
            else if (pick < 20)
                noise_item();
            else
                blink_episode();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, partial window fill, leads off, calibrate, single and
    // double blinks, a blink across the timestamp wrap and a negative spike.
    task automatic test_directed_cases();
        set_idling(0);
        send_item(ACTION_SAMPLE,    12'd0,    1'b0, 32'd0);
        send_item(ACTION_SAMPLE,    12'd4095, 1'b0, 32'd1);
        send_item(ACTION_SAMPLE,    12'd1234, 1'b1, 32'd2);
        send_item(ACTION_SAMPLE,    12'd4095, 1'b0, 32'hFFFF_FFFF);
        send_item(ACTION_CALIBRATE, 12'd2000, 1'b0, 32'd500);
        // A spike of 100 ms becomes the first blink.
        send_item(ACTION_SAMPLE,    12'd4095, 1'b0, 32'd1000);
        send_item(ACTION_SAMPLE,    12'd0,    1'b0, 32'd1100);
        // The pending blink is held while leads are off and reported later.
        send_item(ACTION_SAMPLE,    12'd2000, 1'b1, 32'd1800);
        send_item(ACTION_SAMPLE,    12'd2000, 1'b0, 32'd1900);
        // Two blinks 400 ms apart make a double blink.
        send_item(ACTION_SAMPLE,    12'd4095, 1'b0, 32'd3000);
        send_item(ACTION_SAMPLE,    12'd0,    1'b0, 32'd3050);
        send_item(ACTION_SAMPLE,    12'd4095, 1'b0, 32'd3400);
        send_item(ACTION_SAMPLE,    12'd0,    1'b0, 32'd3450);
        // A blink whose spike spans the timestamp wrap.
        send_item(ACTION_CALIBRATE, 12'd2048, 1'b0, 32'd0);
        send_item(ACTION_SAMPLE,    12'd0,    1'b0, 32'hFFFF_FFF0);
        send_item(ACTION_SAMPLE,    12'd4095, 1'b0, 32'h0000_0020);
        send_item(ACTION_SAMPLE,    12'd2048, 1'b0, 32'h0000_0400);
        send_item(ACTION_SAMPLE,    12'd2048, 1'b0, 32'h0000_0500);
        settle_block();
        stamp_ms = 32'h0000_2000;
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            set_idling(phase);
            random_traffic(270);
        end
        settle_block();
    endtask

    // The receiver holds off while the sender keeps offering, so the output
    // register fills and the input stalls; afterwards the sender pauses until
    // every result is back before carrying on.
    task automatic test_backpressure();
        set_idling(0);
        hold_requests++;
        random_traffic(20);
        settle_block();
        random_traffic(10);
        settle_block();
    endtask

    task automatic test_config_extremes();
        // Lowest threshold, widest blink range, no refractory or double window,
        // no dead zone, a divisor of 16.
        apply_config(16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd16);
        set_idling(1);
        random_traffic(70);
        // Highest threshold, empty blink range, longest times, widest dead
        // zone, zero divisor treated as one.
        apply_config(16'd4095, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd4095, 16'd0);
        set_idling(2);
        random_traffic(70);
        // Zero threshold through ignored upper bits: a spike never ends.
        // Unused upper bits of the dead zone and divisor are set as well.
        apply_config(16'hF000, 16'd30, 16'd300, 16'd250, 16'd650, 16'hF005, 16'hFFFF);
        set_idling(3);
        random_traffic(70);
    endtask

    task automatic test_random_configs();
        int n;
        for (n = 0; n < 4; n++) begin
            apply_config(16'($urandom_range(20, 300)), 16'($urandom_range(0, 100)),
                         16'($urandom_range(100, 600)), 16'($urandom_range(0, 400)),
                         16'($urandom_range(200, 1200)), 16'($urandom_range(0, 60)),
                         16'($urandom_range(1, 16)));
            set_idling(n);
            random_traffic(70);
        end
    endtask

    task automatic test_reset_config();
        apply_config(16'd80, 16'd30, 16'd300, 16'd250, 16'd650, 16'd10, 16'd1);
        set_idling(3);
        random_traffic(100);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        reset_detector_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_backpressure();
        test_config_extremes();
        test_random_configs();
        test_reset_config();

        settle_block();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/eogbg_pkg.sv
rtl/eogbg_div.sv
rtl/eogbg_window.sv
rtl/eog_blink_gaze_detector_unit.sv
bench/testbench.sv
